// ===== hw/rtl/enfp_pkg.sv =====
// shared types and constants for the escaped node file parser
// no dependencies; imported by every module of the block
package enfp_pkg;

   // event codes carried on the result channel
   localparam logic [3:0] EV_NODE_START  = 4'd0;
   localparam logic [3:0] EV_SERVER_ID   = 4'd1;
   localparam logic [3:0] EV_CLIENT_ID   = 4'd2;
   localparam logic [3:0] EV_SPEED       = 4'd3;
   localparam logic [3:0] EV_LIGHT       = 4'd4;
   localparam logic [3:0] EV_TOP_ORDER   = 4'd5;
   localparam logic [3:0] EV_IGNORED     = 4'd6;
   localparam logic [3:0] EV_NODE_END    = 4'd7;
   localparam logic [3:0] EV_BAD_HEADER  = 4'd8;
   localparam logic [3:0] EV_BAD_VERSION = 4'd9;
   localparam logic [3:0] EV_BAD_SIZE    = 4'd10;
   localparam logic [3:0] EV_GOOD_END    = 4'd11;
   localparam logic [3:0] EV_BAD_END     = 4'd12;
   localparam logic [3:0] EV_HEADER_OK   = 4'd13;

   // register indexes on the csr port
   localparam logic [1:0] REG_ACCEPTED_VERSION        = 2'd0;
   localparam logic [1:0] REG_ACCEPTED_CLIENT_VERSION = 2'd1;
   localparam logic [1:0] REG_HEADER_ATTR_SIZE        = 2'd2;

   localparam logic [31:0] ACCEPTED_VERSION_RST        = 32'd3;
   localparam logic [31:0] ACCEPTED_CLIENT_VERSION_RST = 32'd23;
   localparam logic [15:0] HEADER_ATTR_SIZE_RST        = 16'd140;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [31:0] accepted_version;
      logic [31:0] accepted_client_version;
      logic [15:0] header_attr_size;
   } enfp_cfg_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [7:0]  attribute_code;
      logic [31:0] value_a;
      logic [15:0] value_b;
      logic        run_end;
   } enfp_res_type;

   typedef struct packed {
      logic [QUEUE_CW-1:0] count;
      logic                room;
   } enfp_qstat_type;

endpackage

// ===== hw/rtl/enfp_csr.sv =====
// configuration registers of the escaped node file parser, apb-style access
// depends on enfp_pkg
module enfp_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output enfp_pkg::enfp_cfg_type cfg
);
   import enfp_pkg::*;

   enfp_cfg_type cfg_ff;
   logic         wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accepted_version        <= ACCEPTED_VERSION_RST;
         cfg_ff.accepted_client_version <= ACCEPTED_CLIENT_VERSION_RST;
         cfg_ff.header_attr_size        <= HEADER_ATTR_SIZE_RST;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_ACCEPTED_VERSION:        cfg_ff.accepted_version <= csr_pwdata;
            REG_ACCEPTED_CLIENT_VERSION: cfg_ff.accepted_client_version <= csr_pwdata;
            REG_HEADER_ATTR_SIZE:        cfg_ff.header_attr_size <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ACCEPTED_VERSION:        csr_prdata = cfg_ff.accepted_version;
         REG_ACCEPTED_CLIENT_VERSION: csr_prdata = cfg_ff.accepted_client_version;
         REG_HEADER_ATTR_SIZE:        csr_prdata = {16'd0, cfg_ff.header_attr_size};
         default:                     csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== hw/rtl/enfp_parse.sv =====
// input register, unescaping and parse state machine of the node file parser
// depends on enfp_pkg; gives up to two results per byte to the result queue
module enfp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  enfp_pkg::enfp_cfg_type cfg,
   input  logic                   room,
   output logic [1:0]             res_n,
   output enfp_pkg::enfp_res_type res0,
   output enfp_pkg::enfp_res_type res1
);
   import enfp_pkg::*;

   localparam logic [7:0]  ESC_BYTE   = 8'hFD;
   localparam logic [7:0]  NODE_OPEN  = 8'hFE;
   localparam logic [7:0]  NODE_CLOSE = 8'hFF;
   localparam logic [15:0] HEADER_LEN = 16'd13;
   localparam logic [15:0] SKIP_LEN   = 16'd132;
   localparam logic [7:0]  CODE_SERVER_ID = 8'h10;
   localparam logic [7:0]  CODE_CLIENT_ID = 8'h11;
   localparam logic [7:0]  CODE_SPEED     = 8'h14;
   localparam logic [7:0]  CODE_LIGHT     = 8'h2A;
   localparam logic [7:0]  CODE_TOP_ORDER = 8'h2B;

   typedef enum logic [3:0] {
      PH_HEADER      = 4'd0,
      PH_VERSION     = 4'd1,
      PH_CLIENT      = 4'd2,
      PH_SKIP        = 4'd3,
      PH_NODE_START  = 4'd4,
      PH_NODE_HEAD   = 4'd5,
      PH_ATTR_CODE   = 4'd6,
      PH_ATTR_SIZE   = 4'd7,
      PH_ATTR_VALUE  = 4'd8,
      PH_ATTR_SKIP   = 4'd9,
      PH_ENDED       = 4'd10
   } phase_type;

   function automatic logic [2:0] needed_size(input logic [7:0] code);
      case (code)
         CODE_SERVER_ID, CODE_CLIENT_ID, CODE_SPEED: needed_size = 3'd2;
         CODE_LIGHT:                                 needed_size = 3'd4;
         CODE_TOP_ORDER:                             needed_size = 3'd1;
         default:                                    needed_size = 3'd0;
      endcase
   endfunction

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // parse state
   logic        esc_ff, esc_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] size_ff, size_in;
   logic [31:0] ver_ff, ver_in;
   logic        stop_ff, stop_in;
   logic [7:0]  prev_ff, prev_in;

   logic         fire, accept, have, good, p_valid, e_valid;
   logic [15:0]  cnt_inc;
   logic [31:0]  acc_gather, acc_head;
   logic [1:0]   head_lane;
   logic [7:0]   want;
   logic [2:0]   need;
   enfp_res_type p_res, e_res;

   assign fire       = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | room;
   assign accept     = req_tvalid & req_tready;

   assign cnt_inc    = cnt_ff + 16'd1;
   assign acc_gather = acc_ff | ({24'd0, in_byte_ff} << {cnt_ff[1:0], 3'b000});
   assign head_lane  = cnt_ff[1:0] - 2'd1;
   assign acc_head   = acc_ff | ({24'd0, in_byte_ff} << {head_lane, 3'b000});
   assign need       = needed_size(code_ff);

   always_comb begin
      case (cnt_ff)
         16'd4:   want = NODE_OPEN;
         16'd10:  want = 8'd1;
         16'd11:  want = cfg.header_attr_size[7:0];
         16'd12:  want = cfg.header_attr_size[15:8];
         default: want = 8'd0;
      endcase
   end

   always_comb begin
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_byte_in  = accept ? req_tdata : in_byte_ff;
      in_last_in  = accept ? req_tlast : in_last_ff;

      esc_in   = esc_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      code_in  = code_ff;
      size_in  = size_ff;
      ver_in   = ver_ff;
      stop_in  = stop_ff;
      prev_in  = prev_ff;
      have     = 1'b0;
      good     = 1'b0;
      p_valid  = 1'b0;
      e_valid  = 1'b0;
      p_res    = '0;
      e_res    = '0;

      if (fire && !stop_ff) begin
         // unescape: a pending escape makes this byte literal
         if (esc_ff) begin
            esc_in = 1'b0;
            have   = 1'b1;
         end else if (in_byte_ff == ESC_BYTE) begin
            esc_in = ~in_last_ff;
         end else begin
            have = 1'b1;
         end

         if (have) begin
            prev_in = in_byte_ff;
            unique case (phase_ff)
               PH_HEADER: begin
                  if (in_byte_ff != want) begin
                     stop_in = 1'b1;
                     p_valid = 1'b1;
                     p_res.event_res = EV_BAD_HEADER;
                  end else begin
                     cnt_in = cnt_inc;
                     if (cnt_inc >= HEADER_LEN) begin
                        phase_in = PH_VERSION;
                        cnt_in   = 16'd0;
                        acc_in   = 32'd0;
                     end
                  end
               end
               PH_VERSION: begin
                  acc_in = acc_gather;
                  cnt_in = cnt_inc;
                  if (cnt_inc >= 16'd4) begin
                     ver_in   = acc_gather;
                     phase_in = PH_CLIENT;
                     cnt_in   = 16'd0;
                     acc_in   = 32'd0;
                  end
               end
               PH_CLIENT: begin
                  acc_in = acc_gather;
                  cnt_in = cnt_inc;
                  if (cnt_inc >= 16'd4) begin
                     cnt_in  = 16'd0;
                     p_valid = 1'b1;
                     p_res.value_a = ver_ff;
                     p_res.value_b = acc_gather[15:0];
                     if (ver_ff != cfg.accepted_version &&
                         acc_gather != cfg.accepted_client_version) begin
                        stop_in = 1'b1;
                        p_res.event_res = EV_BAD_VERSION;
                     end else begin
                        phase_in = PH_SKIP;
                        p_res.event_res = EV_HEADER_OK;
                     end
                  end
               end
               PH_SKIP: begin
                  cnt_in = cnt_inc;
                  if (cnt_inc >= SKIP_LEN) begin
                     phase_in = PH_NODE_START;
                     cnt_in   = 16'd0;
                  end
               end
               PH_NODE_START: begin
                  if (in_byte_ff == NODE_OPEN) begin
                     phase_in = PH_NODE_HEAD;
                     cnt_in   = 16'd0;
                     acc_in   = 32'd0;
                  end else begin
                     phase_in = PH_ENDED;
                  end
               end
               PH_NODE_HEAD: begin
                  if (cnt_ff == 16'd0) begin
                     code_in = in_byte_ff;
                     cnt_in  = 16'd1;
                     acc_in  = 32'd0;
                  end else begin
                     acc_in = acc_head;
                     cnt_in = cnt_inc;
                     if (cnt_inc >= 16'd5) begin
                        phase_in = PH_ATTR_CODE;
                        cnt_in   = 16'd0;
                        p_valid  = 1'b1;
                        p_res.event_res      = EV_NODE_START;
                        p_res.attribute_code = code_ff;
                        p_res.value_a        = acc_head;
                     end
                  end
               end
               PH_ATTR_CODE: begin
                  if (in_byte_ff == NODE_CLOSE) begin
                     phase_in = PH_NODE_START;
                     p_valid  = 1'b1;
                     p_res.event_res = EV_NODE_END;
                  end else begin
                     code_in  = in_byte_ff;
                     phase_in = PH_ATTR_SIZE;
                     cnt_in   = 16'd0;
                     acc_in   = 32'd0;
                  end
               end
               PH_ATTR_SIZE: begin
                  acc_in = acc_gather;
                  cnt_in = cnt_inc;
                  if (cnt_inc >= 16'd2) begin
                     size_in = acc_gather[15:0];
                     cnt_in  = 16'd0;
                     acc_in  = 32'd0;
                     p_res.attribute_code = code_ff;
                     p_res.value_b        = acc_gather[15:0];
                     if (need == 3'd0) begin
                        // unknown attribute: report and skip its value
                        phase_in = (acc_gather[15:0] == 16'd0) ? PH_ATTR_CODE : PH_ATTR_SKIP;
                        p_valid  = 1'b1;
                        p_res.event_res = EV_IGNORED;
                     end else if (acc_gather[15:0] != {13'd0, need}) begin
                        stop_in = 1'b1;
                        p_valid = 1'b1;
                        p_res.event_res = EV_BAD_SIZE;
                     end else begin
                        phase_in = PH_ATTR_VALUE;
                     end
                  end
               end
               PH_ATTR_VALUE: begin
                  acc_in = acc_gather;
                  cnt_in = cnt_inc;
                  if (cnt_inc >= size_ff) begin
                     phase_in = PH_ATTR_CODE;
                     cnt_in   = 16'd0;
                     p_valid  = 1'b1;
                     p_res.attribute_code = code_ff;
                     p_res.value_a        = acc_gather;
                     case (code_ff)
                        CODE_SERVER_ID: p_res.event_res = EV_SERVER_ID;
                        CODE_CLIENT_ID: p_res.event_res = EV_CLIENT_ID;
                        CODE_SPEED:     p_res.event_res = EV_SPEED;
                        CODE_LIGHT: begin
                           p_res.event_res = EV_LIGHT;
                           p_res.value_a   = {16'd0, acc_gather[15:0]};
                           p_res.value_b   = acc_gather[31:16];
                        end
                        default:        p_res.event_res = EV_TOP_ORDER;
                     endcase
                  end
               end
               PH_ATTR_SKIP: begin
                  cnt_in = cnt_inc;
                  if (cnt_inc >= size_ff) begin
                     phase_in = PH_ATTR_CODE;
                     cnt_in   = 16'd0;
                  end
               end
               PH_ENDED: begin
                  // decoded data after the closing byte
                  stop_in = 1'b1;
                  p_valid = 1'b1;
                  p_res.event_res = EV_BAD_END;
               end
               default: ;
            endcase
         end

         if (in_last_ff && !stop_in) begin
            good    = (phase_in == PH_ENDED) && (prev_in == NODE_CLOSE);
            e_valid = 1'b1;
            e_res.event_res = good ? EV_GOOD_END : EV_BAD_END;
         end
      end

      // last-marked byte rearms everything but the registers
      if (fire && in_last_ff) begin
         esc_in   = 1'b0;
         phase_in = PH_HEADER;
         cnt_in   = 16'd0;
         acc_in   = 32'd0;
         code_in  = 8'd0;
         size_in  = 16'd0;
         ver_in   = 32'd0;
         stop_in  = 1'b0;
         prev_in  = 8'd0;
      end
   end

   always_comb begin
      res_n = {1'b0, p_valid} + {1'b0, e_valid};
      res0  = p_valid ? p_res : e_res;
      res1  = e_res;
      res0.run_end = ~(p_valid & e_valid);
      res1.run_end = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         esc_ff      <= 1'b0;
         phase_ff    <= PH_HEADER;
         cnt_ff      <= 16'd0;
         acc_ff      <= 32'd0;
         code_ff     <= 8'd0;
         size_ff     <= 16'd0;
         ver_ff      <= 32'd0;
         stop_ff     <= 1'b0;
         prev_ff     <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         esc_ff      <= esc_in;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         acc_ff      <= acc_in;
         code_ff     <= code_in;
         size_ff     <= size_in;
         ver_ff      <= ver_in;
         stop_ff     <= stop_in;
         prev_ff     <= prev_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

endmodule

// ===== hw/rtl/enfp_queue.sv =====
// result queue of the node file parser: takes up to two results a cycle,
// gives one a cycle on the result channel while rsp_tready is high; depends on enfp_pkg
module enfp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             res_n,
   input  enfp_pkg::enfp_res_type res0,
   input  enfp_pkg::enfp_res_type res1,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output enfp_pkg::enfp_res_type rsp_res,
   output enfp_pkg::enfp_qstat_type stat
);
   import enfp_pkg::*;

   enfp_res_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, wp_in, wp_next;
   logic [QUEUE_AW-1:0] rp_ff, rp_in;
   logic [QUEUE_CW-1:0] cnt_ff, cnt_in;
   logic                pop;

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_res    = slot_ff[rp_ff];
   assign wp_next    = wp_ff + 1'b1;

   // room for a full pair of results, whatever leaves this cycle
   assign stat.count = cnt_ff;
   assign stat.room  = (cnt_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));

   always_comb begin
      wp_in  = wp_ff + QUEUE_AW'(res_n);
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + QUEUE_CW'(res_n) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (res_n != 2'd0) slot_ff[wp_ff] <= res0;
      if (res_n == 2'd2) slot_ff[wp_next] <= res1;
   end

endmodule

// ===== hw/rtl/escaped_node_file_parser.sv =====
// top level of the escaped node file parser: csr block, parser, result queue
// depends on enfp_pkg, enfp_csr, enfp_parse, enfp_queue
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/req_tready  tdata raw byte, tlast last byte of file
//   rsp       out         rsp_tvalid/rsp_tready  tuser event, tdata code/values, tlast run end
//   csr       in          apb psel/penable       three registers at 0x0, 0x4, 0x8
//
// one byte a cycle sustained while the queue has room; a byte is registered on
// acceptance in the input register, parsed by the phase logic once the queue has
// room, and its results (none, one or two) are written to a four-entry queue that
// drives rsp; req_tready drops only while a byte waits and the queue lacks room for
// two results; a byte giving two results adds one result of backlog that the queue absorbs
// synchronous reset clears control state and loads register defaults; no sweep
module escaped_node_file_parser (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_byte
   input  logic        req_tlast,   // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] attribute_code, [39:8] value_a, [55:40] value_b
   output logic [3:0]  rsp_tuser,   // [3:0] event_res
   output logic        rsp_tlast,   // run_end
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import enfp_pkg::*;

   enfp_cfg_type   cfg;
   enfp_qstat_type queue_stat;
   enfp_res_type   res0, res1, rsp_res;
   logic [1:0]     res_n;

   enfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unescape and parse, one byte per cycle while the queue has room
   enfp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg),
      .room       (queue_stat.room),
      .res_n      (res_n),
      .res0       (res0),
      .res1       (res1)
   );

   // results in order, decoupled from the rsp stall
   enfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .res_n      (res_n),
      .res0       (res0),
      .res1       (res1),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res),
      .stat       (queue_stat)
   );

   assign rsp_tdata = {rsp_res.value_b, rsp_res.value_a, rsp_res.attribute_code};
   assign rsp_tuser = rsp_res.event_res;
   assign rsp_tlast = rsp_res.run_end;

`ifndef NO_ASSERTIONS
   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_stat.count <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // results are only written when a full pair fits
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      (res_n != 2'd0) |-> queue_stat.room)
      else $error("results written without room");

   // a second result of a byte always closes the run
   a_pair_end: assert property (@(posedge clock) disable iff (reset)
      (res_n == 2'd2) |-> (!res0.run_end && res1.run_end))
      else $error("run end misplaced on result pair");
`endif

endmodule
